FILE: rtl/core/psc_pkg.sv
`default_nettype none

package psc_pkg;

  localparam int unsigned BATTERY_COUNT = 4;
  localparam int unsigned SAMPLE_W      = 10;

  typedef enum logic [2:0] {
    OP_CONTROL = 3'd0,
    OP_SECOND  = 3'd1,
    OP_TENTH   = 3'd2,
    OP_WRITE   = 3'd3,
    OP_READ    = 3'd4
  } psc_op_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_ON    = 2'd1,
    MODE_WAIT  = 2'd2,
    MODE_SLEEP = 2'd3
  } psc_mode_e;

  // Byte register map
  localparam logic [7:0] ADDR_CMD           = 8'h00;
  localparam logic [7:0] ADDR_BEACON_EN     = 8'h01;
  localparam logic [7:0] ADDR_BEACON_PERIOD = 8'h02;
  localparam logic [7:0] ADDR_WAKE_HOURS    = 8'h03;
  localparam logic [7:0] ADDR_WAKE_MINUTES  = 8'h04;
  localparam logic [7:0] ADDR_WAKE_SECONDS  = 8'h05;
  localparam logic [7:0] ADDR_STOP_DEFAULT  = 8'h06;
  localparam logic [7:0] ADDR_WD_DEFAULT    = 8'h07;
  localparam logic [7:0] ADDR_SAMPLES_END   = 8'h08;
  localparam logic [7:0] ADDR_BEACON_EN_RD  = 8'h08;
  localparam logic [7:0] ADDR_STATE_RD      = 8'h09;
  localparam logic [7:0] ADDR_WD_DEFAULT_RD = 8'h10;
  localparam logic [7:0] ADDR_VERSION       = 8'hC0;
  localparam logic [7:0] VERSION_ID         = 8'h04;

  localparam logic [7:0] CMD_POWER_ON = 8'd1;
  localparam logic [7:0] CMD_SLEEP    = 8'd2;

  // APB register indexes (bit 2 of the byte address)
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_REED_HOLD = 1'b1;

  localparam logic [9:0] THRESHOLD_RST = 10'd665;
  localparam logic [7:0] REED_HOLD_RST = 8'd4;

  localparam logic [7:0] SIXTY_LESS_ONE     = 8'd59;
  localparam logic [7:0] STATUS_PER_IDLE    = 8'd50;
  localparam logic [7:0] STATUS_PER_ON      = 8'd20;
  localparam logic [7:0] STATUS_PER_ON_LOW  = 8'd5;
  localparam logic [7:0] STATUS_PER_WAIT    = 8'd1;
  localparam logic [7:0] STATUS_PER_SLEEP   = 8'd200;
  localparam logic [7:0] STATUS_PER_RST     = 8'd100;
  localparam logic [7:0] BEACON_PER_RST     = 8'd20;
  localparam logic [7:0] WAKE_SECONDS_RST   = 8'd5;
  localparam logic [7:0] WATCHDOG_WAKE_SECS = 8'd2;
  localparam logic [7:0] STOP_RST           = 8'd60;
  localparam logic [7:0] WATCHDOG_MIN_RST   = 8'd60;

  typedef struct packed {
    logic [2:0] operation;
    logic       reed_closed;
    logic [9:0] battery_a;
    logic [9:0] battery_b;
    logic [9:0] battery_c;
    logic [9:0] battery_d;
    logic [7:0] reg_addr;
    logic [7:0] reg_data;
  } psc_in_t;

  typedef struct packed {
    logic       power_enable;
    logic       status_led;
    logic       beacon_led;
    logic [1:0] supply_state;
    logic       battery_low;
    logic [7:0] read_data;
  } psc_out_t;

  typedef struct packed {
    logic [7:0] count;
    logic       released;
    logic       led_force;
    logic       toggle;
  } psc_reed_t;

  // One reed-switch sample: count down while held, re-arm on release.
  function automatic psc_reed_t reed_step(input logic [7:0] count, input logic released,
                                          input logic closed, input logic [7:0] hold);
    psc_reed_t r;
    r.toggle = 1'b0;
    if (closed) begin
      r.count     = count - 8'd1;
      r.led_force = 1'b1;
      r.released  = released;
    end else begin
      r.count     = hold;
      r.led_force = 1'b0;
      r.released  = 1'b1;
    end
    if (r.released && (r.count == 8'd0)) begin
      r.count     = hold;
      r.released  = 1'b0;
      r.led_force = 1'b0;
      r.toggle    = 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/power_supervisor_controller_unit.sv
`default_nettype none

// Each accepted input beat passes the input register, then state update and
// the result register in one pass, before it leaves as a result beat.
// Throughput: one beat per cycle; only a stalled output holds the input side.
// Reset: asynchronous, active low; supervisor state goes idle with defaults,
// both pipeline stages empty, configuration registers at their reset values.
module power_supervisor_controller_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_stall_o,
  input  wire psc_pkg::psc_in_t   in_data_i,
  output      logic               out_valid_o,
  input  wire logic               out_stall_i,
  output      psc_pkg::psc_out_t  out_data_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);
  import psc_pkg::*;

  // ---------------------------------------------------------------------
  // Pipeline control
  // ---------------------------------------------------------------------
  psc_in_t  in_q;
  logic     in_vld_q;
  psc_out_t res_q, res_d;
  logic     res_vld_q;
  logic     adv;      // result register free to take the next beat
  logic     fire;     // the held input beat is processed this cycle
  logic     in_acc;

  assign adv        = !(res_vld_q && out_stall_i);
  assign fire       = in_vld_q && adv;
  assign in_stall_o = in_vld_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = res_vld_q;
  assign out_data_o  = res_q;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  logic [9:0] thresh_q;
  logic [7:0] reed_hold_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == CFG_REED_HOLD) ? {24'd0, reed_hold_q} : {22'd0, thresh_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESHOLD_RST;
      reed_hold_q <= REED_HOLD_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_THRESHOLD) thresh_q <= pwdata[9:0];
      else                           reed_hold_q <= pwdata[7:0];
    end
  end

  // ---------------------------------------------------------------------
  // Supervisor state
  // ---------------------------------------------------------------------
  // sample slots cover the whole read map; absent batteries stay at zero
  psc_mode_e  mode_q, mode_d;
  logic [7:0] reed_cnt_q, reed_cnt_d;
  logic       reed_rel_q, reed_rel_d;
  logic       reed_force_q, reed_force_d;
  logic [9:0] samp_q [4];
  logic [9:0] samp_d [4];
  logic       low_q, low_d;
  logic       bcn_en_q, bcn_en_d;
  logic [7:0] bcn_per_q, bcn_per_d;
  logic [7:0] bcn_cnt_q, bcn_cnt_d;
  logic [7:0] st_per_q, st_per_d;
  logic [7:0] st_cnt_q, st_cnt_d;
  logic [7:0] wake_q [3];      // hours, minutes, seconds
  logic [7:0] wake_d [3];
  logic [7:0] wake_def_q [3];
  logic [7:0] wake_def_d [3];
  logic [7:0] stop_q, stop_d;
  logic [7:0] stop_def_q, stop_def_d;
  logic [7:0] wd_min_q, wd_min_d;
  logic [7:0] wd_def_q, wd_def_d;
  logic [7:0] wd_sec_q, wd_sec_d;
  logic [2:0] led_q, led_d;    // bit0 status, bit1 beacon, bit2 power

  logic [7:0] hold_val;
  logic [9:0] batt_in [4];
  psc_reed_t  reed;
  logic [9:0] rd_samp;
  logic [7:0] rd_byte;

  assign hold_val = (reed_hold_q == 8'd0) ? 8'd1 : reed_hold_q;
  assign reed     = reed_step(reed_cnt_q, reed_rel_q, in_q.reed_closed, hold_val);
  assign rd_samp  = samp_q[in_q.reg_addr[2:1]];

  always_comb begin
    batt_in[0] = in_q.battery_a;
    batt_in[1] = in_q.battery_b;
    batt_in[2] = in_q.battery_c;
    batt_in[3] = in_q.battery_d;
  end

  // register read mux
  always_comb begin
    rd_byte = 8'd0;
    if (in_q.reg_addr < ADDR_SAMPLES_END) begin
      rd_byte = in_q.reg_addr[0] ? {6'd0, rd_samp[9:8]} : rd_samp[7:0];
    end else if (in_q.reg_addr == ADDR_BEACON_EN_RD) begin
      rd_byte = {7'd0, bcn_en_q};
    end else if (in_q.reg_addr == ADDR_STATE_RD) begin
      rd_byte = {6'd0, mode_q};
    end else if (in_q.reg_addr == ADDR_WD_DEFAULT_RD) begin
      rd_byte = wd_def_q;
    end else if (in_q.reg_addr == ADDR_VERSION) begin
      rd_byte = VERSION_ID;
    end
  end

  // single pass over one beat
  always_comb begin
    mode_d       = mode_q;
    reed_cnt_d   = reed_cnt_q;
    reed_rel_d   = reed_rel_q;
    reed_force_d = reed_force_q;
    samp_d       = samp_q;
    low_d        = low_q;
    bcn_en_d     = bcn_en_q;
    bcn_per_d    = bcn_per_q;
    bcn_cnt_d    = bcn_cnt_q;
    st_per_d     = st_per_q;
    st_cnt_d     = st_cnt_q;
    wake_d       = wake_q;
    wake_def_d   = wake_def_q;
    stop_d       = stop_q;
    stop_def_d   = stop_def_q;
    wd_min_d     = wd_min_q;
    wd_def_d     = wd_def_q;
    wd_sec_d     = wd_sec_q;
    led_d        = led_q;
    res_d        = res_q;

    if (fire) begin
      case (in_q.operation)
        OP_CONTROL: begin
          low_d = 1'b0;
          for (int i = 0; i < 4; i++) begin
            if (i < BATTERY_COUNT) begin
              samp_d[i] = batt_in[i];
              if (batt_in[i] < thresh_q) low_d = 1'b1;
            end
          end
          case (mode_q)
            MODE_IDLE: begin
              led_d[2]     = 1'b0;
              st_per_d     = STATUS_PER_IDLE;
              bcn_en_d     = 1'b0;
              reed_cnt_d   = reed.count;
              reed_rel_d   = reed.released;
              reed_force_d = reed.led_force;
              if (reed.toggle) mode_d = MODE_ON;
            end
            MODE_ON: begin
              led_d[2]     = 1'b1;
              st_per_d     = low_d ? STATUS_PER_ON_LOW : STATUS_PER_ON;
              reed_cnt_d   = reed.count;
              reed_rel_d   = reed.released;
              reed_force_d = reed.led_force;
              if (reed.toggle) mode_d = MODE_IDLE;
            end
            MODE_WAIT: begin
              led_d[2] = 1'b1;
              st_per_d = STATUS_PER_WAIT;
              if (stop_q == 8'd0) begin
                wake_d = wake_def_q;
                mode_d = MODE_SLEEP;
                stop_d = stop_def_q;
              end
            end
            default: begin
              led_d[2] = 1'b0;
              st_per_d = STATUS_PER_SLEEP;
              if (wake_q[0] == 8'd0 && wake_q[1] == 8'd0 && wake_q[2] == 8'd0)
                mode_d = MODE_ON;
            end
          endcase
        end

        OP_SECOND: begin
          if (mode_q == MODE_SLEEP) begin
            if (wake_q[2] != 8'd0) begin
              wake_d[2] = wake_q[2] - 8'd1;
            end else if (wake_q[1] != 8'd0) begin
              wake_d[1] = wake_q[1] - 8'd1;
              wake_d[2] = SIXTY_LESS_ONE;
            end else if (wake_q[0] != 8'd0) begin
              wake_d[0] = wake_q[0] - 8'd1;
              wake_d[1] = SIXTY_LESS_ONE;
            end
          end
          if (mode_q == MODE_WAIT && stop_q != 8'd0) stop_d = stop_q - 8'd1;
          // minute watchdog: a zero default stops it
          if (mode_q == MODE_ON && wd_def_q != 8'd0) begin
            if (wd_sec_q != 8'd0) begin
              wd_sec_d = wd_sec_q - 8'd1;
            end else begin
              wd_sec_d = SIXTY_LESS_ONE;
              if (wd_min_q != 8'd0) begin
                wd_min_d = wd_min_q - 8'd1;
              end else begin
                wake_def_d[0] = 8'd0;
                wake_def_d[1] = 8'd0;
                wake_def_d[2] = WATCHDOG_WAKE_SECS;
                stop_d        = stop_def_q;
                mode_d        = MODE_WAIT;
                wd_min_d      = wd_def_q;
              end
            end
          end
        end

        OP_TENTH: begin
          led_d[1] = 1'b0;
          if (bcn_en_q) begin
            if (bcn_cnt_q != 8'd0) begin
              bcn_cnt_d = bcn_cnt_q - 8'd1;
            end else begin
              led_d[1]  = 1'b1;
              bcn_cnt_d = bcn_per_q;
            end
          end
          if (reed_force_q) begin
            led_d[0] = 1'b1;
          end else if (st_cnt_q != 8'd0) begin
            led_d[0] = 1'b0;
            st_cnt_d = st_cnt_q - 8'd1;
          end else begin
            led_d[0] = 1'b1;
            st_cnt_d = st_per_q;
          end
        end

        OP_WRITE: begin
          case (in_q.reg_addr)
            ADDR_CMD: begin
              if (in_q.reg_data == CMD_POWER_ON) begin
                mode_d = MODE_ON;
              end else if (in_q.reg_data == CMD_SLEEP) begin
                stop_d = stop_def_q;
                mode_d = MODE_WAIT;
              end
            end
            ADDR_BEACON_EN:     bcn_en_d      = (in_q.reg_data != 8'd0);
            ADDR_BEACON_PERIOD: bcn_per_d     = in_q.reg_data;
            ADDR_WAKE_HOURS:    wake_def_d[0] = in_q.reg_data;
            ADDR_WAKE_MINUTES:  wake_def_d[1] = in_q.reg_data;
            ADDR_WAKE_SECONDS:  wake_def_d[2] = in_q.reg_data;
            ADDR_STOP_DEFAULT:  stop_def_d    = in_q.reg_data;
            ADDR_WD_DEFAULT: begin
              wd_def_d = in_q.reg_data;
              wd_min_d = in_q.reg_data;
            end
            default: ;
          endcase
        end

        OP_READ: begin
          wd_min_d = wd_def_q;
        end

        default: ;
      endcase

      res_d.power_enable = led_d[2];
      res_d.status_led   = led_d[0];
      res_d.beacon_led   = led_d[1];
      res_d.supply_state = mode_d;
      res_d.battery_low  = low_d;
      res_d.read_data    = (in_q.operation == OP_READ) ? rd_byte : 8'd0;
    end
  end

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      res_vld_q    <= 1'b0;
      mode_q       <= MODE_IDLE;
      reed_cnt_q   <= REED_HOLD_RST;
      reed_rel_q   <= 1'b1;
      reed_force_q <= 1'b0;
      for (int i = 0; i < 4; i++) samp_q[i] <= '0;
      low_q        <= 1'b0;
      bcn_en_q     <= 1'b0;
      bcn_per_q    <= BEACON_PER_RST;
      bcn_cnt_q    <= BEACON_PER_RST;
      st_per_q     <= STATUS_PER_RST;
      st_cnt_q     <= STATUS_PER_RST;
      wake_q[0]    <= 8'd0;
      wake_q[1]    <= 8'd0;
      wake_q[2]    <= WAKE_SECONDS_RST;
      wake_def_q[0] <= 8'd0;
      wake_def_q[1] <= 8'd0;
      wake_def_q[2] <= WAKE_SECONDS_RST;
      stop_q       <= STOP_RST;
      stop_def_q   <= STOP_RST;
      wd_min_q     <= WATCHDOG_MIN_RST;
      wd_def_q     <= WATCHDOG_MIN_RST;
      wd_sec_q     <= SIXTY_LESS_ONE;
      led_q        <= 3'd0;
    end else begin
      if (in_acc)    in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (adv)       res_vld_q <= in_vld_q;
      mode_q       <= mode_d;
      reed_cnt_q   <= reed_cnt_d;
      reed_rel_q   <= reed_rel_d;
      reed_force_q <= reed_force_d;
      samp_q       <= samp_d;
      low_q        <= low_d;
      bcn_en_q     <= bcn_en_d;
      bcn_per_q    <= bcn_per_d;
      bcn_cnt_q    <= bcn_cnt_d;
      st_per_q     <= st_per_d;
      st_cnt_q     <= st_cnt_d;
      wake_q       <= wake_d;
      wake_def_q   <= wake_def_d;
      stop_q       <= stop_d;
      stop_def_q   <= stop_def_d;
      wd_min_q     <= wd_min_d;
      wd_def_q     <= wd_def_d;
      wd_sec_q     <= wd_sec_d;
      led_q        <= led_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) in_q <= in_data_i;
    res_q <= res_d;
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // power switch level moves only on a control step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (led_q[2] != $past(led_q[2])) |-> $past(fire && in_q.operation == OP_CONTROL))
    else $error("power level changed outside a control step");

  // a processed beat always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> res_vld_q)
    else $error("processed beat lost");

  // read byte is zero unless the beat was a register read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_q.operation != OP_READ) |=> (res_q.read_data == 8'd0))
    else $error("read byte set on a non-read beat");

endmodule

`default_nettype wire

FILE: verif/psc_output_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the config port, predicts each result beat and
// compares it field by field against what the unit returns.
module psc_output_checker
  import psc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  psc_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  psc_out_t    out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic        pready_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output int          mismatches_o,
  output int          pending_o
);

  localparam int WAKE_H = 0;
  localparam int WAKE_M = 1;
  localparam int WAKE_S = 2;

  // config copy
  logic [9:0] threshold;
  logic [7:0] reed_hold;

  // supervisor state copy; absent batteries keep a zero sample
  psc_mode_e  mode;
  logic [7:0] reed_count;
  logic       reed_released;
  logic       reed_led_force;
  logic [9:0] samples [4];
  logic       low_flag;
  logic       beacon_en;
  logic [7:0] beacon_period;
  logic [7:0] beacon_count;
  logic [7:0] status_period;
  logic [7:0] status_count;
  logic [7:0] wake_cnt [3];
  logic [7:0] wake_dflt [3];
  logic [7:0] stop_cnt;
  logic [7:0] stop_dflt;
  logic [7:0] wd_min;
  logic [7:0] wd_min_dflt;
  logic [7:0] wd_sec;
  logic       status_lvl;
  logic       beacon_lvl;
  logic       power_lvl;

  psc_out_t   awaited_outputs [$];
  psc_out_t   oldest;
  int         mismatches;

  // one reed sample; returns 1 when power should toggle
  function automatic logic reed_sample(input logic closed);
    logic [7:0] hold;
    hold = (reed_hold == 8'd0) ? 8'd1 : reed_hold;
    if (closed) begin
      reed_count     = reed_count - 8'd1;
      reed_led_force = 1'b1;
    end else begin
      reed_count     = hold;
      reed_led_force = 1'b0;
      reed_released  = 1'b1;
    end
    if (reed_released && reed_count == 8'd0) begin
      reed_count     = hold;
      reed_released  = 1'b0;
      reed_led_force = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic psc_out_t step_supervisor(input psc_in_t beat);
    psc_out_t   res;
    logic [7:0] rd;
    logic [9:0] level [4];
    logic [9:0] s;
    logic       status;
    logic       beacon;
    int         i;
    rd = 8'd0;
    case (beat.operation)
      OP_CONTROL: begin
        level[0] = beat.battery_a;
        level[1] = beat.battery_b;
        level[2] = beat.battery_c;
        level[3] = beat.battery_d;
        low_flag = 1'b0;
        for (i = 0; i < 4; i++) begin
          if (i < BATTERY_COUNT) begin
            samples[i] = level[i];
            if (level[i] < threshold) low_flag = 1'b1;
          end
        end
        case (mode)
          MODE_IDLE: begin
            power_lvl     = 1'b0;
            status_period = STATUS_PER_IDLE;
            beacon_en     = 1'b0;
            if (reed_sample(beat.reed_closed)) mode = MODE_ON;
          end
          MODE_ON: begin
            power_lvl     = 1'b1;
            status_period = low_flag ? STATUS_PER_ON_LOW : STATUS_PER_ON;
            if (reed_sample(beat.reed_closed)) mode = MODE_IDLE;
          end
          MODE_WAIT: begin
            power_lvl     = 1'b1;
            status_period = STATUS_PER_WAIT;
            if (stop_cnt == 8'd0) begin
              wake_cnt = wake_dflt;
              mode     = MODE_SLEEP;
              stop_cnt = stop_dflt;
            end
          end
          default: begin
            power_lvl     = 1'b0;
            status_period = STATUS_PER_SLEEP;
            if (wake_cnt[WAKE_H] == 8'd0 && wake_cnt[WAKE_M] == 8'd0 &&
                wake_cnt[WAKE_S] == 8'd0)
              mode = MODE_ON;
          end
        endcase
      end
      OP_SECOND: begin
        if (mode == MODE_SLEEP) begin
          if (wake_cnt[WAKE_S] != 8'd0) begin
            wake_cnt[WAKE_S] = wake_cnt[WAKE_S] - 8'd1;
          end else if (wake_cnt[WAKE_M] != 8'd0) begin
            wake_cnt[WAKE_M] = wake_cnt[WAKE_M] - 8'd1;
            wake_cnt[WAKE_S] = SIXTY_LESS_ONE;
          end else if (wake_cnt[WAKE_H] != 8'd0) begin
            wake_cnt[WAKE_H] = wake_cnt[WAKE_H] - 8'd1;
            wake_cnt[WAKE_M] = SIXTY_LESS_ONE;
          end
        end
        if (mode == MODE_WAIT && stop_cnt != 8'd0) stop_cnt = stop_cnt - 8'd1;
        if (mode == MODE_ON && wd_min_dflt != 8'd0) begin
          if (wd_sec != 8'd0) begin
            wd_sec = wd_sec - 8'd1;
          end else begin
            wd_sec = SIXTY_LESS_ONE;
            if (wd_min != 8'd0) begin
              wd_min = wd_min - 8'd1;
            end else begin
              // watchdog expiry: short nap, then back on
              wake_dflt[WAKE_H] = 8'd0;
              wake_dflt[WAKE_M] = 8'd0;
              wake_dflt[WAKE_S] = WATCHDOG_WAKE_SECS;
              stop_cnt          = stop_dflt;
              mode              = MODE_WAIT;
              wd_min            = wd_min_dflt;
            end
          end
        end
      end
      OP_TENTH: begin
        beacon = 1'b0;
        if (beacon_en) begin
          if (beacon_count != 8'd0) begin
            beacon_count = beacon_count - 8'd1;
          end else begin
            beacon       = 1'b1;
            beacon_count = beacon_period;
          end
        end
        if (reed_led_force) begin
          status = 1'b1;
        end else if (status_count != 8'd0) begin
          status       = 1'b0;
          status_count = status_count - 8'd1;
        end else begin
          status       = 1'b1;
          status_count = status_period;
        end
        status_lvl = status;
        beacon_lvl = beacon;
      end
      OP_WRITE: begin
        case (beat.reg_addr)
          ADDR_CMD: begin
            if (beat.reg_data == CMD_POWER_ON) begin
              mode = MODE_ON;
            end else if (beat.reg_data == CMD_SLEEP) begin
              stop_cnt = stop_dflt;
              mode     = MODE_WAIT;
            end
          end
          ADDR_BEACON_EN:     beacon_en = (beat.reg_data != 8'd0);
          ADDR_BEACON_PERIOD: beacon_period = beat.reg_data;
          ADDR_WAKE_HOURS:    wake_dflt[WAKE_H] = beat.reg_data;
          ADDR_WAKE_MINUTES:  wake_dflt[WAKE_M] = beat.reg_data;
          ADDR_WAKE_SECONDS:  wake_dflt[WAKE_S] = beat.reg_data;
          ADDR_STOP_DEFAULT:  stop_dflt = beat.reg_data;
          ADDR_WD_DEFAULT: begin
            wd_min_dflt = beat.reg_data;
            wd_min      = beat.reg_data;
          end
          default: ;
        endcase
      end
      OP_READ: begin
        if (beat.reg_addr < ADDR_SAMPLES_END) begin
          s  = samples[beat.reg_addr[2:1]];
          rd = beat.reg_addr[0] ? {6'd0, s[9:8]} : s[7:0];
        end else begin
          case (beat.reg_addr)
            ADDR_BEACON_EN_RD:  rd = {7'd0, beacon_en};
            ADDR_STATE_RD:      rd = {6'd0, mode};
            ADDR_WD_DEFAULT_RD: rd = wd_min_dflt;
            ADDR_VERSION:       rd = VERSION_ID;
            default:            rd = 8'd0;
          endcase
        end
        wd_min = wd_min_dflt;
      end
      default: ;
    endcase
    res.power_enable = power_lvl;
    res.status_led   = status_lvl;
    res.beacon_led   = beacon_lvl;
    res.supply_state = mode;
    res.battery_low  = low_flag;
    res.read_data    = rd;
    return res;
  endfunction

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold      = THRESHOLD_RST;
      reed_hold      = REED_HOLD_RST;
      mode           = MODE_IDLE;
      reed_count     = REED_HOLD_RST;
      reed_released  = 1'b1;
      reed_led_force = 1'b0;
      samples        = '{default: '0};
      low_flag       = 1'b0;
      beacon_en      = 1'b0;
      beacon_period  = BEACON_PER_RST;
      beacon_count   = BEACON_PER_RST;
      status_period  = STATUS_PER_RST;
      status_count   = STATUS_PER_RST;
      wake_cnt       = '{8'd0, 8'd0, WAKE_SECONDS_RST};
      wake_dflt      = '{8'd0, 8'd0, WAKE_SECONDS_RST};
      stop_cnt       = STOP_RST;
      stop_dflt      = STOP_RST;
      wd_min         = WATCHDOG_MIN_RST;
      wd_min_dflt    = WATCHDOG_MIN_RST;
      wd_sec         = SIXTY_LESS_ONE;
      status_lvl     = 1'b0;
      beacon_lvl     = 1'b0;
      power_lvl      = 1'b0;
      awaited_outputs.delete();
      mismatches     = 0;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      // results first: any beat leaving now belongs to an earlier input
      if (out_valid_i && !out_stall_i) begin
        if (awaited_outputs.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, expected none, got %h",
                   $time, out_data_i);
          mismatches++;
        end else begin
          oldest = awaited_outputs.pop_front();
          check_field("power_enable", 8'(oldest.power_enable), 8'(out_data_i.power_enable));
          check_field("status_led", 8'(oldest.status_led), 8'(out_data_i.status_led));
          check_field("beacon_led", 8'(oldest.beacon_led), 8'(out_data_i.beacon_led));
          check_field("supply_state", 8'(oldest.supply_state),
                      8'(out_data_i.supply_state));
          check_field("battery_low", 8'(oldest.battery_low), 8'(out_data_i.battery_low));
          check_field("read_data", oldest.read_data, out_data_i.read_data);
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i[2] == CFG_REED_HOLD) reed_hold = pwdata_i[7:0];
        else                             threshold = pwdata_i[9:0];
      end
      if (in_valid_i && !in_stall_i) awaited_outputs.push_back(step_supervisor(in_data_i));
      mismatches_o <= mismatches;
      pending_o    <= awaited_outputs.size();
    end
  end

endmodule

FILE: verif/tb_power_supervisor_controller_unit.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the power supervisor unit. Prediction and
// comparison live in psc_output_checker, instantiated beside the DUT.
module tb_power_supervisor_controller_unit;
  import psc_pkg::*;

  localparam int         PHASE_ITEMS   = 150;
  localparam int         QUIET_LIMIT   = 2000;  // cycles with no beat on any port
  localparam int         SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
  localparam logic [7:0] ADDR_INIT_FLAG = 8'hC1;
  localparam logic [7:0] ADDR_UNMAPPED  = 8'hFF;

  // per-phase config: thresholds and reed hold counts, extremes included
  localparam logic [9:0] THR_PLAN  [4] = '{10'd700, 10'd0, 10'd1023, 10'd512};
  localparam logic [7:0] HOLD_PLAN [4] = '{8'd3, 8'd0, 8'd2, 8'd255};

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  psc_in_t     in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  psc_out_t    out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          pending;
  int          quiet_cycles = 0;

  // stimulus-side knobs, owned by the main initial block
  int          phase        = 0;
  int          phase_items  = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic [9:0]  cur_thr      = THRESHOLD_RST;
  logic [7:0]  cur_hold     = REED_HOLD_RST;
  logic        reed_held    = 1'b0;

  // receiver-side hold-off, owned by the receiver process
  int          hold_left    = 0;
  logic        held_off     = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  power_supervisor_controller_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  psc_output_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  // Receiver: random stalls per phase, plus one long hold-off in phase 2 so
  // the pipeline fills and the unit has to stall its input.
  always @(posedge clk) begin
    if (phase == 2 && !held_off && phase_items >= 30) begin
      hold_left = 80;
      held_off  = 1'b1;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: any beat on either channel or a config access counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Battery sample: half the time hugging the threshold, else anywhere.
  function automatic logic [9:0] battery_level();
    int v;
    if ($urandom_range(0, 1) == 1) v = int'(cur_thr) + int'($urandom_range(0, 8)) - 4;
    else                           v = int'($urandom_range(0, SAMPLE_MAX));
    if (v < 0)               v = 0;
    else if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return 10'(v);
  endfunction

  // Fields an operation does not use are still randomised.
  function automatic psc_in_t make_beat(input psc_op_e op, input logic [7:0] addr,
                                        input logic [7:0] data);
    psc_in_t b;
    b.operation   = op;
    b.reed_closed = 1'($urandom_range(0, 1));
    b.battery_a   = battery_level();
    b.battery_b   = battery_level();
    b.battery_c   = battery_level();
    b.battery_d   = battery_level();
    b.reg_addr    = addr;
    b.reg_data    = data;
    return b;
  endfunction

  // Offer one beat; valid stays up until it is taken, whatever stall does.
  task automatic send_beat(input psc_in_t b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    phase_items++;
  endtask

  // Stop offering and wait until every predicted result has been taken.
  // The extra edge lets the checker count a beat taken on this very edge.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Free mix of every operation; the reed is held in runs so toggles happen.
  task automatic run_mix(input int count);
    psc_in_t    b;
    int         pick;
    logic [7:0] addr;
    logic [7:0] data;
    repeat (count) begin
      if ($urandom_range(0, 99) < 15) reed_held = ~reed_held;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
        b.reed_closed = reed_held;
      end else if (pick < 58) begin
        b = make_beat(OP_SECOND, 8'($urandom), 8'($urandom));
      end else if (pick < 70) begin
        b = make_beat(OP_TENTH, 8'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        addr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        data = 8'($urandom);
        // mostly small, meaningful settings so timers actually expire
        if ($urandom_range(0, 7) != 0) begin
          case (addr)
            ADDR_CMD:           data = 8'($urandom_range(0, 3));
            ADDR_BEACON_EN:     data = 8'($urandom_range(0, 1));
            ADDR_BEACON_PERIOD: data = 8'($urandom_range(0, 4));
            ADDR_WAKE_HOURS:    data = 8'($urandom_range(0, 9) == 0);
            ADDR_WAKE_MINUTES:  data = 8'($urandom_range(0, 1));
            ADDR_WAKE_SECONDS:  data = 8'($urandom_range(0, 3));
            ADDR_STOP_DEFAULT:  data = 8'($urandom_range(0, 3));
            ADDR_WD_DEFAULT:    data = 8'($urandom_range(0, 1));
            default: ;
          endcase
        end
        b = make_beat(OP_WRITE, addr, data);
      end else if (pick < 97) begin
        case ($urandom_range(0, 3))
          0:       addr = 8'($urandom);
          1:       addr = 8'($urandom_range(0, 9));
          2:       addr = ($urandom_range(0, 1) == 1) ? ADDR_VERSION : ADDR_INIT_FLAG;
          default: addr = ($urandom_range(0, 1) == 1) ? ADDR_WD_DEFAULT_RD : ADDR_STATE_RD;
        endcase
        b = make_beat(OP_READ, addr, 8'($urandom));
      end else begin
        // undefined operation codes above the last real one
        b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
        b.operation = 3'(OP_READ) + 3'($urandom_range(1, 3));
      end
      send_beat(b);
    end
  endtask

  // Command a sleep with short timers, then tick through stop, sleep and wake.
  task automatic sleep_cycle();
    psc_in_t b;
    int      pick;
    send_beat(make_beat(OP_WRITE, ADDR_STOP_DEFAULT, 8'($urandom_range(0, 2))));
    send_beat(make_beat(OP_WRITE, ADDR_WAKE_HOURS, 8'd0));
    send_beat(make_beat(OP_WRITE, ADDR_WAKE_MINUTES, 8'd0));
    send_beat(make_beat(OP_WRITE, ADDR_WAKE_SECONDS, 8'($urandom_range(0, 3))));
    send_beat(make_beat(OP_WRITE, ADDR_CMD, CMD_SLEEP));
    repeat ($urandom_range(8, 16)) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        b = make_beat(OP_SECOND, 8'($urandom), 8'($urandom));
      end else if (pick < 85) begin
        b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
        b.reed_closed = 1'b0;
      end else begin
        b = make_beat(OP_TENTH, 8'($urandom), 8'($urandom));
      end
      send_beat(b);
    end
  endtask

  // Hold the magnet for about the hold count (capped), with LED ticks mixed in,
  // then release. Longer presses run the counter past zero and wrap it.
  task automatic press_reed();
    psc_in_t b;
    int      presses;
    presses = ((cur_hold == 8'd0) ? 1 : int'(cur_hold)) + int'($urandom_range(0, 3));
    if (presses > 12) presses = 12;
    while (presses > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
        b.reed_closed = 1'b1;
        presses--;
      end else begin
        b = make_beat(OP_TENTH, 8'($urandom), 8'($urandom));
      end
      send_beat(b);
    end
    b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
    b.reed_closed = 1'b0;
    send_beat(b);
  endtask

  // Power on with a one-minute watchdog and feed it mostly seconds for a fixed
  // run of beats, no reads, so that it can force the wait and sleep sequence.
  task automatic run_watchdog();
    psc_in_t b;
    int      pick;
    send_beat(make_beat(OP_WRITE, ADDR_WD_DEFAULT, 8'd1));
    send_beat(make_beat(OP_WRITE, ADDR_CMD, CMD_POWER_ON));
    repeat (145) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) begin
        b = make_beat(OP_SECOND, 8'($urandom), 8'($urandom));
      end else if (pick < 95) begin
        b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
        b.reed_closed = 1'b0;
      end else begin
        b = make_beat(OP_TENTH, 8'($urandom), 8'($urandom));
      end
      send_beat(b);
    end
  endtask

  // Directed opening: register map corners, battery extremes, every operation.
  task automatic directed_beats();
    psc_in_t b;
    int      a;
    send_beat(make_beat(OP_READ, ADDR_VERSION, 8'($urandom)));
    send_beat(make_beat(OP_READ, ADDR_INIT_FLAG, 8'($urandom)));
    send_beat(make_beat(OP_READ, ADDR_UNMAPPED, 8'($urandom)));
    send_beat(make_beat(OP_WRITE, ADDR_UNMAPPED, 8'hFF));
    b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
    b.reed_closed = 1'b0;
    b.battery_a   = '0;
    b.battery_b   = '0;
    b.battery_c   = '0;
    b.battery_d   = '0;
    send_beat(b);
    b.battery_a   = '1;
    b.battery_b   = '1;
    b.battery_c   = '1;
    b.battery_d   = '1;
    send_beat(b);
    for (a = 0; a < ADDR_SAMPLES_END; a += 3) send_beat(make_beat(OP_READ, 8'(a), 8'd0));
    // one battery a step under the threshold, the rest right on it
    b.battery_a   = cur_thr - 10'd1;
    b.battery_b   = cur_thr;
    b.battery_c   = cur_thr;
    b.battery_d   = cur_thr;
    send_beat(b);
    send_beat(make_beat(OP_WRITE, ADDR_BEACON_EN, 8'd1));
    send_beat(make_beat(OP_WRITE, ADDR_BEACON_PERIOD, 8'd0));
    send_beat(make_beat(OP_TENTH, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(OP_TENTH, 8'($urandom), 8'($urandom)));
    b = make_beat(OP_CONTROL, 8'hFF, 8'hFF);
    b.operation = 3'(OP_READ) + 3'd1;
    send_beat(b);
    b.operation = '1;
    send_beat(b);
    send_beat(make_beat(OP_WRITE, ADDR_CMD, 8'd0));
    send_beat(make_beat(OP_WRITE, ADDR_CMD, CMD_POWER_ON));
    b = make_beat(OP_CONTROL, 8'($urandom), 8'($urandom));
    b.reed_closed = 1'b0;
    send_beat(b);
    // watchdog stopped by a zero default
    send_beat(make_beat(OP_WRITE, ADDR_WD_DEFAULT, 8'd0));
    send_beat(make_beat(OP_SECOND, 8'($urandom), 8'($urandom)));
    send_beat(make_beat(OP_WRITE, ADDR_STOP_DEFAULT, 8'd0));
    send_beat(make_beat(OP_WRITE, ADDR_CMD, CMD_SLEEP));
    send_beat(b);
    send_beat(make_beat(OP_READ, ADDR_STATE_RD, 8'($urandom)));
    send_beat(make_beat(OP_READ, ADDR_BEACON_EN_RD, 8'($urandom)));
    send_beat(make_beat(OP_READ, ADDR_WD_DEFAULT_RD, 8'($urandom)));
  endtask

  initial begin
    int pick;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < 4; phase++) begin
      // idling: receiver-heavy gaps first, then sender-heavy, then none
      case (phase)
        0:       begin send_idle_pct = 37; stall_pct = 77; end
        1:       begin send_idle_pct = 77; stall_pct = 37; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      if (phase > 0) drain();
      cur_thr  = THR_PLAN[phase];
      cur_hold = HOLD_PLAN[phase];
      write_config(CFG_THRESHOLD, 32'(cur_thr));
      write_config(CFG_REED_HOLD, 32'(cur_hold));
      phase_items = 0;
      if (phase == 0) directed_beats();
      if (phase == 3) run_watchdog();
      while (phase_items < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          run_mix($urandom_range(10, 30));
        end else if (pick < 8) begin
          sleep_cycle();
        end else begin
          // in phase 1 the sender also waits for a fully empty unit first
          if (phase == 1) drain();
          press_reed();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else                 $display("FAIL");
    $finish;
  end

endmodule
